// ===== rtl/ipdx_pkg.sv =====
`default_nettype none
package ipdx_pkg;

  typedef enum logic [1:0] {
    PH_SEEK_START,
    PH_SEEK_COLON,
    PH_EMIT,
    PH_DONE
  } phase_t;

  localparam int START_LEN = 5;
  localparam int END_LEN = 8;
  localparam int START_CW = $clog2(START_LEN + 1);
  localparam int END_CW = $clog2(END_LEN + 1);
  localparam int END_IW = $clog2(END_LEN);

  localparam logic [7:0] COLON_CHAR = 8'h3A;
  localparam logic [7:0] LIMIT_RESET = 8'd12;
  localparam logic [7:0] LIMIT_MIN = 8'(END_LEN);

  // Result of one parsed byte, handed from the parser to the output stage.
  typedef struct packed {
    logic emit;
    logic fin;
  } ipdx_result_t;

  // Characters of "+IPD,".
  function automatic logic [7:0] start_char(input logic [START_CW-1:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h2B;
      3'd1:    c = 8'h49;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h44;
      3'd4:    c = 8'h2C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Characters of "0,CLOSED".
  function automatic logic [7:0] end_char(input logic [END_IW-1:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h30;
      3'd1:    c = 8'h2C;
      3'd2:    c = 8'h43;
      3'd3:    c = 8'h4C;
      3'd4:    c = 8'h4F;
      3'd5:    c = 8'h53;
      3'd6:    c = 8'h45;
      default: c = 8'h44;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ipd_payload_extractor.sv =====
`default_nettype none
// Channel   Direction  tdata           tlast        tuser
// s_axis    in         in_byte [7:0]   buffer_end   -
// m_axis    out        out_byte [7:0]  final_byte   -
// cfg       in         cfg_wr_data = bytes_from_end_marker, written when cfg_wr_en
//
// A request is taken into an input register and parsed while it is held there. Its
// result lands in the output register when the parser advances, which raises
// m_axis_tvalid for a payload byte.
// One request per cycle is sustained while m_axis_tready stays high; the single input
// register and the output register set this figure. Reset clears the parser state,
// both valid flags and restores the register to 12. A stall on m_axis holds the input
// register and drops s_axis_tready only while both registers are full.
module ipd_payload_extractor
  import ipdx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire logic       s_axis_tlast,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic      [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tlast,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data
);

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         in_last;
  logic         out_valid;
  logic [7:0]   out_byte;
  logic         out_last;
  logic [7:0]   limit_reg;
  logic [7:0]   limit;
  logic         advance;
  ipdx_result_t result;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  // Values below the end marker's length behave as the length itself.
  assign limit         = (limit_reg < LIMIT_MIN) ? LIMIT_MIN : limit_reg;

  ipdx_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .in_byte    (in_byte),
    .buffer_end (in_last),
    .limit      (limit),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_reg <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_reg <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= result.emit;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      out_byte <= in_byte;
      out_last <= result.fin;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_byte;
  assign m_axis_tlast  = out_last;

endmodule
`default_nettype wire

// ===== rtl/ipdx_parser.sv =====
`default_nettype none
module ipdx_parser
  import ipdx_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         step,
  input  wire logic [7:0]   in_byte,
  input  wire logic         buffer_end,
  input  wire logic [7:0]   limit,
  output ipdx_result_t      result
);

  phase_t                phase, phase_next;
  logic [START_CW-1:0]   start_cnt, start_cnt_next;
  logic [END_CW-1:0]     end_cnt, end_cnt_next;
  logic [7:0]            trail_cnt, trail_cnt_next;
  logic                  fin;

  always_comb begin
    phase_next     = phase;
    start_cnt_next = start_cnt;
    end_cnt_next   = end_cnt;
    trail_cnt_next = trail_cnt;
    fin            = 1'b0;
    result         = '0;
    unique case (phase)
      PH_SEEK_START: begin
        if (start_cnt < START_CW'(START_LEN) && in_byte == start_char(start_cnt)) begin
          start_cnt_next = start_cnt + 1'b1;
        end else begin
          start_cnt_next = (in_byte == start_char('0)) ? START_CW'(1) : '0;
        end
        if (start_cnt_next >= START_CW'(START_LEN)) begin
          phase_next = PH_SEEK_COLON;
        end
      end
      PH_SEEK_COLON: begin
        if (in_byte == COLON_CHAR) begin
          phase_next     = PH_EMIT;
          end_cnt_next   = '0;
          trail_cnt_next = '0;
        end
      end
      PH_EMIT: begin
        result.emit = 1'b1;
        if (end_cnt >= END_CW'(END_LEN)) begin
          if (trail_cnt != 8'hFF) begin
            trail_cnt_next = trail_cnt + 8'd1;
          end
        end else begin
          if (in_byte == end_char(end_cnt[END_IW-1:0])) begin
            end_cnt_next = end_cnt + 1'b1;
          end else begin
            end_cnt_next = (in_byte == end_char('0)) ? END_CW'(1) : '0;
          end
          if (end_cnt_next >= END_CW'(END_LEN)) begin
            end_cnt_next   = END_CW'(END_LEN);
            trail_cnt_next = 8'(END_LEN);
          end
        end
        if (end_cnt_next >= END_CW'(END_LEN) && trail_cnt_next >= limit) begin
          fin        = 1'b1;
          phase_next = PH_DONE;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase
    result.fin = result.emit & (fin | buffer_end);
    // The last byte of a buffer sends the parser back to seeking.
    if (buffer_end) begin
      phase_next     = PH_SEEK_START;
      start_cnt_next = '0;
      end_cnt_next   = '0;
      trail_cnt_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SEEK_START;
      start_cnt <= '0;
      end_cnt   <= '0;
      trail_cnt <= '0;
    end else if (step) begin
      phase     <= phase_next;
      start_cnt <= start_cnt_next;
      end_cnt   <= end_cnt_next;
      trail_cnt <= trail_cnt_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ipdx_checker.sv =====
`default_nettype none
module ipdx_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast
);

  // A stalled result must stay offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // With the output side empty, the block must take a new request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // A fresh result must trace back to an accepted request, held in the input register and then the output register.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !$past(m_axis_tvalid) && !$past(rst) && !$past(rst, 2)
      |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a matching request");

endmodule

bind ipd_payload_extractor ipdx_checker u_ipdx_checker (.*);
`default_nettype wire
